>>> design/cbem_pkg.sv
// Shared types and constants for the checked big-endian memory port.
package cbem_pkg;

  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
  localparam int unsigned BANKS     = 4;
  localparam int unsigned BANK_AW   = MEM_AW - $clog2(BANKS);

  localparam logic [23:0] PROBE_LO = 24'hFEFFF0;
  localparam logic [24:0] PROBE_HI = 25'hFF0000;
  localparam logic [7:0]  TAG_LO   = 8'h20;
  localparam logic [7:0]  TAG_HI   = 8'h28;
  localparam logic [23:0] IO_BASE  = 24'hC00000;

  localparam logic [24:0] MEM_TOP_RST   = 25'h0010000;
  localparam logic [23:0] LOW_BOUND_RST = 24'h000000;

  typedef enum logic [1:0] {
    REG_MEM_TOP   = 2'd0,
    REG_LOW_BOUND = 2'd1,
    REG_IO_PASS   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_LONG = 2'd2
  } size_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_ADDR_ERR = 3'd2,
    ST_ABORT    = 3'd3,
    ST_PROBE    = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [23:0] fault;
    logic        access;
  } chk_t;

endpackage

>>> design/cbem_check.sv
// Access checker: probe window, range, privilege and alignment decisions.
module cbem_check
  import cbem_pkg::*;
(
  input  logic        mode,
  input  logic [31:0] address,
  input  logic [1:0]  size,
  input  logic        supervisor,
  input  logic        in_instruction,
  input  logic [24:0] mem_top,
  input  logic [23:0] low_bound,
  input  logic        io_pass,
  output chk_t        chk
);

  logic [7:0]  tag;
  logic [23:0] a;
  logic [2:0]  w;
  logic [24:0] end_a;
  logic        tag_ok;
  logic        probe;
  logic        over;
  logic        checked;
  logic        odd;
  status_t     st;

  assign tag   = address[31:24];
  assign a     = address[23:0];
  assign w     = (size == SZ_BYTE) ? 3'd1 : (size == SZ_WORD) ? 3'd2 : 3'd4;
  assign end_a = {1'b0, a} + {22'd0, w};

  assign tag_ok  = (tag == 8'd0) || ((tag >= TAG_LO) && (tag <= TAG_HI));
  assign probe   = !mode && tag_ok && (a >= PROBE_LO) && ({1'b0, a} < PROBE_HI)
                   && (end_a <= PROBE_HI);
  assign over    = end_a > mem_top;
  assign checked = (a < low_bound) || over;
  assign odd     = (size != SZ_BYTE) && a[0];

  always_comb begin
    st = ST_OK;
    if (probe) begin
      st = ST_PROBE;
    end else if (checked) begin
      if (odd) begin
        st = ST_ABORT;
      end else if (a >= IO_BASE) begin
        st = io_pass ? ST_IGNORED : ST_ABORT;
      end else if (!supervisor || over) begin
        st = ST_ABORT;
      end
    end else if (odd) begin
      st = in_instruction ? ST_ADDR_ERR : ST_ABORT;
    end
  end

  assign chk.status = st;
  assign chk.fault  = ((st == ST_ADDR_ERR) || (st == ST_ABORT)) ? a : 24'd0;
  assign chk.access = (st == ST_OK);

endmodule

>>> design/cbem_bank.sv
// One byte-wide bank of the store, synchronous write and registered read.
module cbem_bank
  import cbem_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic               we,
  input  logic [BANK_AW-1:0] addr,
  input  logic [7:0]         wdata,
  output logic [7:0]         rdata
);

  logic [7:0] mem [2**BANK_AW];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/checked_big_endian_memory_access.sv
// Checked big-endian memory port: top level with four byte banks.
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while out_tready is high; each of the four banks does one access per cycle.
// Back pressure holds the result register and stops input until it drains.
// Reset (rst_n low, synchronous) clears control state and loads the register
// defaults; the store itself is undefined until written and has no clearing pass.
module checked_big_endian_memory_access
  import cbem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode, address[31:0], size[1:0], write_data[31:0], supervisor, in_instruction
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[31:0], status[2:0], fault_address[23:0]
  output logic [63:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [24:0] cfg_wdata
);

  logic        mode;
  logic [31:0] address;
  logic [1:0]  size;
  logic [31:0] write_data;
  logic        supervisor;
  logic        in_instruction;

  assign mode           = in_tdata[0];
  assign address        = in_tdata[32:1];
  assign size           = in_tdata[34:33];
  assign write_data     = in_tdata[66:35];
  assign supervisor     = in_tdata[67];
  assign in_instruction = in_tdata[68];

  logic [24:0] mem_top_r;
  logic [23:0] low_bound_r;
  logic        io_pass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_top_r   <= MEM_TOP_RST;
      low_bound_r <= LOW_BOUND_RST;
      io_pass_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MEM_TOP:   mem_top_r   <= cfg_wdata;
        REG_LOW_BOUND: low_bound_r <= cfg_wdata[23:0];
        REG_IO_PASS:   io_pass_r   <= cfg_wdata[0];
        default:       ;
      endcase
    end
  end

  chk_t chk;

  cbem_check u_check (
    .mode           (mode),
    .address        (address),
    .size           (size),
    .supervisor     (supervisor),
    .in_instruction (in_instruction),
    .mem_top        (mem_top_r),
    .low_bound      (low_bound_r),
    .io_pass        (io_pass_r),
    .chk            (chk)
  );

  logic out_valid_r;
  logic acc;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  // index of the last byte of the access: 0, 1 or 3
  logic [1:0] wlast;
  assign wlast = (size == SZ_BYTE) ? 2'd0 : (size == SZ_WORD) ? 2'd1 : 2'd3;

  logic [BANKS-1:0] bank_en;
  logic [7:0]       lane_q [BANKS];

  for (genvar k = 0; k < BANKS; k++) begin : g_bank
    logic [1:0]        off;
    logic [1:0]        sel;
    logic [MEM_AW-1:0] baddr;
    logic [7:0]        wbyte;

    assign off   = 2'(k) - address[1:0];
    assign sel   = wlast - off;
    assign baddr = address[MEM_AW-1:0] + MEM_AW'(off);
    assign wbyte = write_data[8*sel +: 8];
    assign bank_en[k] = acc && chk.access && (off <= wlast);

    cbem_bank u_bank (
      .clk   (clk),
      .en    (bank_en[k]),
      .we    (mode),
      .addr  (baddr[MEM_AW-1:2]),
      .wdata (wbyte),
      .rdata (lane_q[k])
    );
  end

  status_t     status_r;
  logic [23:0] fault_r;
  logic        rd_ok_r;
  logic [1:0]  a_lo_r;
  logic [1:0]  wlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= chk.status;
      fault_r  <= chk.fault;
      rd_ok_r  <= chk.access && !mode;
      a_lo_r   <= address[1:0];
      wlast_r  <= wlast;
    end
  end

  logic [31:0] read_data;

  always_comb begin
    read_data = 32'd0;
    if (rd_ok_r) begin
      for (int i = 0; i < BANKS; i++) begin
        if (2'(i) <= wlast_r) begin
          read_data = {read_data[23:0], lane_q[2'(a_lo_r + 2'(i))]};
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, fault_r, status_r, read_data};

  logic [2:0] w_bytes;
  assign w_bytes = 3'(wlast) + 3'd1;

  a_lane_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && chk.access |-> $countones(bank_en) == 32'(w_bytes))
    else $error("bank enables do not match access width");

  a_no_lane_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc && chk.access) |-> bank_en == '0)
    else $error("bank touched by a refused access");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_OK) |-> read_data == 32'd0)
    else $error("nonzero read data with non-ok status");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !((status_r == ST_ADDR_ERR) || (status_r == ST_ABORT))
    |-> fault_r == 24'd0)
    else $error("fault address without error status");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("accepted word produced no result");

endmodule
